### design/gim_pkg.sv
// Shared types, constants and helpers for the Goertzel impedance meter.
// Used by goertzel_impedance_meter_core; depends on nothing else.
package gim_pkg;

  // Field and register widths.
  localparam int SAMPLE_W = 24;
  localparam int STATE_W  = 56;
  localparam int COEFF_W  = 19;
  localparam int WIN_W    = 11;
  localparam int SCALE_W  = 32;
  localparam int OHM_W    = 24;
  localparam int RMS_W    = 24;
  localparam int IMP_W    = 32;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 2;

  // Window bounds.
  localparam int MAX_WINDOW = 1024;
  localparam int WIN_CAP    = (MAX_WINDOW / 8) * 8;
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);

  // Shared multiplier, partial-product split and accumulator.
  localparam int MUL_W   = 32;
  localparam int PART_W  = STATE_W / 2;
  localparam int ACC_W   = 2 * STATE_W + 2;
  localparam int REM_W   = STATE_W + 1;
  localparam int STEP_W  = $clog2(STATE_W);
  localparam int FRAC_W  = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_COEFF  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RMS    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OHMS   = 2'd3;

  // Register reset values.
  localparam logic signed [COEFF_W-1:0] COEFF_RST  = 19'sd92682;
  localparam logic [WIN_W-1:0]          WINDOW_RST = 11'd256;
  localparam logic [SCALE_W-1:0]        RMS_RST    = 32'd23013;
  localparam logic [OHM_W-1:0]          OHMS_RST   = 24'd10922667;

  // Symmetric saturation bounds of the recurrence.
  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W-STATE_W+1){1'b0}}, {(STATE_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PMUL,
    ST_PCLAMP,
    ST_ADDX,
    ST_SUBP2,
    ST_PWR,
    ST_PFIX,
    ST_ROOT,
    ST_RMS,
    ST_RMSSAT,
    ST_OHM
  } state_t;

  // Clamp a wide signed value to the recurrence range.
  function automatic logic signed [STATE_W-1:0] sat_state(
    input logic signed [ACC_W-1:0] v
  );
    logic signed [STATE_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[STATE_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[STATE_W-1:0];
    end else begin
      r = v[STATE_W-1:0];
    end
    return r;
  endfunction

  // Magnitude of a recurrence value; the range is symmetric so it never overflows.
  function automatic logic [STATE_W-1:0] mag_state(input logic signed [STATE_W-1:0] v);
    logic [STATE_W-1:0] n;
    n = v[STATE_W-1] ? -v : v;
    return n;
  endfunction

  // Low or high half of a magnitude, widened to the multiplier port.
  function automatic logic [MUL_W-1:0] half_of(input logic [STATE_W-1:0] m,
                                               input logic hi);
    logic [MUL_W-1:0] r;
    if (hi) begin
      r = MUL_W'(m[STATE_W-1:PART_W]);
    end else begin
      r = MUL_W'(m[PART_W-1:0]);
    end
    return r;
  endfunction

endpackage

### design/goertzel_impedance_meter_core.sv
// Goertzel single-bin impedance meter: recurrence, bin power, square root and scaling.
// One 32x32 multiplier and one accumulator are shared under a small sequencer.
// Depends on gim_pkg.
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+-------------------------------------------
//  in_     | in        | in_tvalid/in_tready   | in_tdata[23:0] sample_uv
//  out_    | out       | out_tvalid/out_tready | out_tdata[23:0] rms, [55:24] impedance
//  cfg_    | in        | cfg_valid/cfg_ready   | cfg_index register, cfg_data value
//
// A sample that does not close a window passes from its beat to the next beat through
// two partial products on the shared multiplier, one floor-and-clamp step and two
// saturating add steps, after which ready is back.
// A sample that closes a window adds 14 multiplier passes for the bin power, a
// bit-serial square root, 3 passes for the scaling and 3 fix-up steps.
// rst_n is synchronous; it restores the register defaults and clears the recurrence.
// The result sits in an output register; the sequencer stalls before loading it only
// while an earlier result has not yet been taken.
module goertzel_impedance_meter_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [gim_pkg::SAMPLE_W-1:0]    in_tdata,   // [23:0] sample_uv
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [gim_pkg::RMS_W+gim_pkg::IMP_W-1:0] out_tdata, // [23:0] rms_amplitude_uv,
                                                      // [55:24] impedance_ohms
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gim_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gim_pkg::CFG_W-1:0]       cfg_data
);

  localparam int SW = gim_pkg::STATE_W;
  localparam int AW = gim_pkg::ACC_W;
  localparam int MW = gim_pkg::MUL_W;
  localparam int PW = gim_pkg::PART_W;
  localparam int RW = gim_pkg::REM_W;
  localparam int OUT_W = gim_pkg::RMS_W + gim_pkg::IMP_W;

  // Configuration registers.
  logic signed [gim_pkg::COEFF_W-1:0] coeff_r;
  logic [gim_pkg::WIN_W-1:0]          win_r;
  logic [gim_pkg::SCALE_W-1:0]        rms_scale_r;
  logic [gim_pkg::OHM_W-1:0]          ohms_r;

  // Sequencer and datapath registers.
  gim_pkg::state_t                state_r, state_nxt;
  logic [gim_pkg::STEP_W-1:0]     step_r, step_nxt;
  logic                           fin_r, fin_nxt;
  logic [gim_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic signed [SW-1:0]           prev_r, prev_nxt;
  logic signed [SW-1:0]           prev2_r, prev2_nxt;
  logic signed [SW-1:0]           t_r, t_nxt;
  logic signed [gim_pkg::SAMPLE_W-1:0] x_r, x_nxt;
  logic signed [AW-1:0]           acc_r, acc_nxt;
  logic [RW-1:0]                  rem_r, rem_nxt;
  logic [SW-1:0]                  root_r, root_nxt;
  logic [gim_pkg::RMS_W-1:0]      rms_r, rms_nxt;
  logic                           out_tvalid_r, out_tvalid_nxt;
  logic [OUT_W-1:0]               out_tdata_r, out_tdata_nxt;

  // Shared multiply-accumulate unit.
  logic [MW-1:0]     mul_a, mul_b;
  logic [1:0]        mul_sh;
  logic              mul_sub;
  logic [2*MW-1:0]   prod;
  logic [AW-1:0]     prod_sh;
  logic signed [AW-1:0] mac_sum;

  // Helpers.
  logic [SW-1:0]              mag_prev, mag_prev2, mag_t;
  logic [MW-1:0]              mag_coeff;
  logic [gim_pkg::CNT_W-1:0]  win_eff;
  logic [gim_pkg::CNT_W-1:0]  win_round;
  logic [gim_pkg::CNT_W-1:0]  cnt_inc;
  logic [RW+1:0]              rem_sh;
  logic [RW+1:0]              trial;
  logic                       root_ge;
  logic [RW+1:0]              rem_diff;
  logic signed [AW-1:0]       x_ext, t_ext, prev2_ext;
  logic                       out_free;

  assign in_tready  = (state_r == gim_pkg::ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_free   = !out_tvalid_r || out_tready;

  // Magnitudes of the operands fed to the multiplier; the coefficient is widened
  // before negation so the most negative value keeps its magnitude.
  assign mag_prev  = gim_pkg::mag_state(prev_r);
  assign mag_prev2 = gim_pkg::mag_state(prev2_r);
  assign mag_t     = gim_pkg::mag_state(t_r);
  assign mag_coeff = coeff_r[gim_pkg::COEFF_W-1] ? -MW'(coeff_r) : MW'(coeff_r);

  // Effective window: rounded down to a multiple of eight, capped, never zero.
  always_comb begin
    win_round = {win_r[gim_pkg::WIN_W-1:3], 3'b000};
    if (win_round > gim_pkg::CNT_W'(gim_pkg::WIN_CAP)) begin
      win_eff = gim_pkg::CNT_W'(gim_pkg::WIN_CAP);
    end else if (win_round == '0) begin
      win_eff = gim_pkg::CNT_W'(8);
    end else begin
      win_eff = win_round;
    end
  end
  assign cnt_inc = cnt_r + 1'b1;

  // Sign-extended operands for the saturating add steps.
  assign x_ext     = {{(AW-gim_pkg::SAMPLE_W){x_r[gim_pkg::SAMPLE_W-1]}}, x_r};
  assign t_ext     = {{(AW-SW){t_r[SW-1]}}, t_r};
  assign prev2_ext = {{(AW-SW){prev2_r[SW-1]}}, prev2_r};

  // Multiplier, partial-product alignment and accumulate.
  assign prod = mul_a * mul_b;
  always_comb begin
    case (mul_sh)
      2'd1:    prod_sh = AW'(prod) << PW;
      2'd2:    prod_sh = AW'(prod) << (2 * PW);
      default: prod_sh = AW'(prod);
    endcase
  end
  assign mac_sum = mul_sub ? (acc_r - $signed(prod_sh)) : (acc_r + $signed(prod_sh));

  // One restoring square-root step: two radicand bits per cycle.
  assign rem_sh   = {rem_r, acc_r[2*SW-1 -: 2]};
  assign trial    = (RW+2)'({root_r, 2'b01});
  assign root_ge  = (rem_sh >= trial);
  assign rem_diff = rem_sh - trial;

  // Sequencer: next state, multiplier operands and datapath updates.
  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    fin_nxt        = fin_r;
    cnt_nxt        = cnt_r;
    prev_nxt       = prev_r;
    prev2_nxt      = prev2_r;
    t_nxt          = t_r;
    x_nxt          = x_r;
    acc_nxt        = acc_r;
    rem_nxt        = rem_r;
    root_nxt       = root_r;
    rms_nxt        = rms_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    mul_a          = '0;
    mul_b          = '0;
    mul_sh         = 2'd0;
    mul_sub        = 1'b0;

    case (state_r)
      gim_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          x_nxt     = in_tdata;
          acc_nxt   = '0;
          step_nxt  = '0;
          fin_nxt   = 1'b0;
          state_nxt = gim_pkg::ST_PMUL;
        end
      end

      // Coefficient times previous value, two partial products.
      gim_pkg::ST_PMUL: begin
        mul_a   = gim_pkg::half_of(mag_prev, step_r[0]);
        mul_b   = mag_coeff;
        mul_sh  = {1'b0, step_r[0]};
        mul_sub = prev_r[SW-1] ^ coeff_r[gim_pkg::COEFF_W-1];
        acc_nxt = mac_sum;
        if (step_r[0]) begin
          step_nxt  = '0;
          state_nxt = gim_pkg::ST_PCLAMP;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end

      // Floor the Q16 product and saturate it.
      gim_pkg::ST_PCLAMP: begin
        t_nxt = gim_pkg::sat_state(acc_r >>> gim_pkg::FRAC_W);
        if (fin_r) begin
          acc_nxt   = '0;
          step_nxt  = '0;
          state_nxt = gim_pkg::ST_PWR;
        end else begin
          state_nxt = gim_pkg::ST_ADDX;
        end
      end

      gim_pkg::ST_ADDX: begin
        t_nxt     = gim_pkg::sat_state(x_ext + t_ext);
        state_nxt = gim_pkg::ST_SUBP2;
      end

      // Close the recurrence step and check for the end of the window.
      gim_pkg::ST_SUBP2: begin
        prev_nxt  = gim_pkg::sat_state(t_ext - prev2_ext);
        prev2_nxt = prev_r;
        cnt_nxt   = cnt_inc;
        if (cnt_inc >= win_eff) begin
          fin_nxt   = 1'b1;
          acc_nxt   = '0;
          step_nxt  = '0;
          state_nxt = gim_pkg::ST_PMUL;
        end else begin
          state_nxt = gim_pkg::ST_IDLE;
        end
      end

      // Bin power: s1*s1 + s2*s2 - s2*p, four partial products per term.
      gim_pkg::ST_PWR: begin
        case (step_r[3:2])
          2'd0: begin
            mul_a = gim_pkg::half_of(mag_prev, step_r[1]);
            mul_b = gim_pkg::half_of(mag_prev, step_r[0]);
          end
          2'd1: begin
            mul_a = gim_pkg::half_of(mag_prev2, step_r[1]);
            mul_b = gim_pkg::half_of(mag_prev2, step_r[0]);
          end
          default: begin
            mul_a   = gim_pkg::half_of(mag_prev2, step_r[1]);
            mul_b   = gim_pkg::half_of(mag_t, step_r[0]);
            mul_sub = (prev2_r[SW-1] == t_r[SW-1]);
          end
        endcase
        mul_sh  = 2'(step_r[1]) + 2'(step_r[0]);
        acc_nxt = mac_sum;
        if (step_r == gim_pkg::STEP_W'(11)) begin
          state_nxt = gim_pkg::ST_PFIX;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end

      // A negative power counts as zero.
      gim_pkg::ST_PFIX: begin
        if (acc_r[AW-1]) begin
          acc_nxt = '0;
        end
        rem_nxt   = '0;
        root_nxt  = '0;
        step_nxt  = '0;
        state_nxt = gim_pkg::ST_ROOT;
      end

      gim_pkg::ST_ROOT: begin
        rem_nxt  = root_ge ? rem_diff[RW-1:0] : rem_sh[RW-1:0];
        root_nxt = {root_r[SW-2:0], root_ge};
        acc_nxt  = acc_r <<< 2;
        if (step_r == gim_pkg::STEP_W'(SW - 1)) begin
          step_nxt  = '0;
          state_nxt = gim_pkg::ST_RMS;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end

      // Magnitude times the RMS scale, two partial products.
      gim_pkg::ST_RMS: begin
        mul_a  = gim_pkg::half_of(root_r, step_r[0]);
        mul_b  = MW'(rms_scale_r);
        mul_sh = {1'b0, step_r[0]};
        acc_nxt = (step_r[0] ? mac_sum : $signed(prod_sh));
        if (step_r[0]) begin
          step_nxt  = '0;
          state_nxt = gim_pkg::ST_RMSSAT;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end

      gim_pkg::ST_RMSSAT: begin
        if (acc_r[AW-1:gim_pkg::FRAC_W+gim_pkg::RMS_W] != '0) begin
          rms_nxt = '1;
        end else begin
          rms_nxt = acc_r[gim_pkg::FRAC_W+gim_pkg::RMS_W-1:gim_pkg::FRAC_W];
        end
        state_nxt = gim_pkg::ST_OHM;
      end

      // Impedance from the saturated RMS value, then hand off the result.
      gim_pkg::ST_OHM: begin
        mul_a = MW'(rms_r);
        mul_b = MW'(ohms_r);
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {prod[gim_pkg::FRAC_W+gim_pkg::IMP_W-1:gim_pkg::FRAC_W], rms_r};
          prev_nxt       = '0;
          prev2_nxt      = '0;
          cnt_nxt        = '0;
          fin_nxt        = 1'b0;
          state_nxt      = gim_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = gim_pkg::ST_IDLE;
      end
    endcase
  end

  // State register and control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= gim_pkg::ST_IDLE;
      step_r       <= '0;
      fin_r        <= 1'b0;
      cnt_r        <= '0;
      prev_r       <= '0;
      prev2_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      step_r       <= step_nxt;
      fin_r        <= fin_nxt;
      cnt_r        <= cnt_nxt;
      prev_r       <= prev_nxt;
      prev2_r      <= prev2_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    t_r         <= t_nxt;
    x_r         <= x_nxt;
    acc_r       <= acc_nxt;
    rem_r       <= rem_nxt;
    root_r      <= root_nxt;
    rms_r       <= rms_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_r     <= gim_pkg::COEFF_RST;
      win_r       <= gim_pkg::WINDOW_RST;
      rms_scale_r <= gim_pkg::RMS_RST;
      ohms_r      <= gim_pkg::OHMS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gim_pkg::REG_COEFF:  coeff_r     <= cfg_data[gim_pkg::COEFF_W-1:0];
        gim_pkg::REG_WINDOW: win_r       <= cfg_data[gim_pkg::WIN_W-1:0];
        gim_pkg::REG_RMS:    rms_scale_r <= cfg_data[gim_pkg::SCALE_W-1:0];
        gim_pkg::REG_OHMS:   ohms_r      <= cfg_data[gim_pkg::OHM_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
